// File: hdl/serial_motor_command_parser_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the serial motor command parser
// Clocked on aclk; the first form is masked while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef SERIAL_MOTOR_COMMAND_PARSER_MACROS_SVH
`define SERIAL_MOTOR_COMMAND_PARSER_MACROS_SVH

// Property checked only outside reset.
`define SMCP_CHECK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked at every edge, reset included.
`define SMCP_CHECK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hdl/smcp_pkg.sv
// ---------------------------------------------------------------------------
// smcp_pkg
// Shared types and character constants of the motor command parser.
// ---------------------------------------------------------------------------
package smcp_pkg;

    typedef enum logic [1:0] {
        STATUS_FORWARD  = 2'd0,
        STATUS_BACKWARD = 2'd1,
        STATUS_STOP     = 2'd2,
        STATUS_UNKNOWN  = 2'd3
    } status_t;

    // One parsed command line, front to back.
    typedef struct packed {
        status_t     status;
        logic [7:0]  command_char;
        logic [6:0]  duty_percent;
    } cmd_entry_t;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;
    localparam logic [7:0] CHAR_UP_B  = 8'h42;
    localparam logic [7:0] CHAR_LO_B  = 8'h62;
    localparam logic [7:0] CHAR_UP_S  = 8'h53;
    localparam logic [7:0] CHAR_LO_S  = 8'h73;

    localparam logic [6:0] DUTY_MAX = 7'd100;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    localparam int TDATA_OUT_W = 24;

endpackage

// File: hdl/smcp_front.sv
// ---------------------------------------------------------------------------
// smcp_front
// Per-character line parser; on newline with a held command classifies it and
// pushes one entry into the command queue.
// ---------------------------------------------------------------------------
module smcp_front #(
    parameter int LINE_BUFFER_BYTES = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,
    output logic                   push_valid,
    output smcp_pkg::cmd_entry_t   push_entry,
    input  logic                   queue_full
);

    localparam int POS_W = $clog2(LINE_BUFFER_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_BUFFER_BYTES - 1);

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_GAP    = 3'd1,
        PH_SIGN   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    logic [POS_W-1:0] pos_reg,   pos_next;
    phase_t           phase_reg, phase_next;
    logic [7:0]       cmd_reg,   cmd_next;
    logic             neg_reg,   neg_next;
    logic [6:0]       acc_reg,   acc_next;

    logic        accept;
    logic [7:0]  c;
    logic        is_blank;
    logic        is_digit;
    logic [3:0]  digit;
    logic [10:0] acc_mac;
    logic [6:0]  acc_sat;
    logic [6:0]  line_value;
    smcp_pkg::status_t status_code;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign c        = s_tdata;

    assign is_blank = (c == smcp_pkg::CHAR_SPACE) || (c == smcp_pkg::CHAR_TAB) ||
                      (c == smcp_pkg::CHAR_VT)    || (c == smcp_pkg::CHAR_FF);
    assign is_digit = (c >= smcp_pkg::CHAR_ZERO) && (c <= smcp_pkg::CHAR_NINE);
    assign digit    = 4'(c - smcp_pkg::CHAR_ZERO);

    // acc * 10 + digit, saturated at 100
    assign acc_mac = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {7'd0, digit};
    assign acc_sat = (acc_mac > 11'(smcp_pkg::DUTY_MAX)) ? smcp_pkg::DUTY_MAX : acc_mac[6:0];

    // sign with no digit, or minus sign: duty 0
    assign line_value = ((phase_reg == PH_SIGN) || neg_reg) ? 7'd0 : acc_reg;

    always_comb begin
        case (cmd_reg)
            smcp_pkg::CHAR_UP_F, smcp_pkg::CHAR_LO_F: status_code = smcp_pkg::STATUS_FORWARD;
            smcp_pkg::CHAR_UP_B, smcp_pkg::CHAR_LO_B: status_code = smcp_pkg::STATUS_BACKWARD;
            smcp_pkg::CHAR_UP_S, smcp_pkg::CHAR_LO_S: status_code = smcp_pkg::STATUS_STOP;
            default:                                  status_code = smcp_pkg::STATUS_UNKNOWN;
        endcase
    end

    always_comb begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        push_valid = 1'b0;

        push_entry.status       = status_code;
        push_entry.command_char = cmd_reg;
        push_entry.duty_percent = line_value;

        if (accept && (c != smcp_pkg::CHAR_CR)) begin
            if (c == smcp_pkg::CHAR_LF) begin
                push_valid = (cmd_reg != smcp_pkg::CHAR_NUL);
                pos_next   = '0;
                phase_next = PH_LEAD;
                cmd_next   = '0;
                neg_next   = 1'b0;
                acc_next   = '0;
            end else if (pos_reg < POS_LAST) begin
                pos_next = pos_reg + 1'b1;
                if (c == smcp_pkg::CHAR_NUL) begin
                    phase_next = PH_DONE;
                end else begin
                    case (phase_reg)
                        PH_LEAD: begin
                            if (!is_blank) begin
                                cmd_next   = c;
                                phase_next = PH_GAP;
                            end
                        end
                        PH_GAP: begin
                            if (!is_blank) begin
                                if ((c == smcp_pkg::CHAR_PLUS) || (c == smcp_pkg::CHAR_MINUS)) begin
                                    neg_next   = (c == smcp_pkg::CHAR_MINUS);
                                    phase_next = PH_SIGN;
                                end else if (is_digit) begin
                                    acc_next   = {3'b000, digit};
                                    phase_next = PH_DIGITS;
                                end else begin
                                    phase_next = PH_DONE;
                                end
                            end
                        end
                        PH_SIGN, PH_DIGITS: begin
                            if (is_digit) begin
                                acc_next   = acc_sat;
                                phase_next = PH_DIGITS;
                            end else begin
                                if (phase_reg == PH_SIGN) begin
                                    acc_next = '0;
                                    neg_next = 1'b0;
                                end
                                phase_next = PH_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end else begin
                // overflow: drop the character, start over
                pos_next   = '0;
                phase_next = PH_LEAD;
                cmd_next   = '0;
                neg_next   = 1'b0;
                acc_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            phase_reg <= PH_LEAD;
            cmd_reg   <= '0;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end else begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

// File: hdl/smcp_queue.sv
// ---------------------------------------------------------------------------
// smcp_queue
// Four-entry command queue between parser and drive stage.
// ---------------------------------------------------------------------------
module smcp_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  smcp_pkg::cmd_entry_t   push_entry,
    output logic                   full,
    input  logic                   pop,
    output smcp_pkg::cmd_entry_t   pop_entry,
    output logic                   empty
);

    smcp_pkg::cmd_entry_t slot_reg [smcp_pkg::QUEUE_DEPTH];

    logic [smcp_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [smcp_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [smcp_pkg::QUEUE_CNT_W-1:0] count_reg,  count_next;

    logic do_push;
    logic do_pop;

    assign full      = (count_reg == smcp_pkg::QUEUE_CNT_W'(smcp_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: hdl/smcp_back.sv
// ---------------------------------------------------------------------------
// smcp_back
// Applies queued commands to the drive levels and holds the result register.
// ---------------------------------------------------------------------------
module smcp_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               queue_empty,
    input  smcp_pkg::cmd_entry_t               queue_entry,
    output logic                               queue_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [smcp_pkg::TDATA_OUT_W-1:0]   m_tdata
);

    logic       fwd_reg,  fwd_next;
    logic       rev_reg,  rev_next;
    logic [6:0] duty_reg, duty_next;

    logic       valid_reg;
    logic [1:0] status_reg;
    logic [7:0] cmd_reg;

    // refill the result register when it is empty or being taken
    assign queue_pop = !queue_empty && (!valid_reg || m_tready);

    always_comb begin
        fwd_next  = fwd_reg;
        rev_next  = rev_reg;
        duty_next = duty_reg;
        case (queue_entry.status)
            smcp_pkg::STATUS_FORWARD: begin
                fwd_next  = 1'b1;
                rev_next  = 1'b0;
                duty_next = queue_entry.duty_percent;
            end
            smcp_pkg::STATUS_BACKWARD: begin
                fwd_next  = 1'b0;
                rev_next  = 1'b1;
                duty_next = queue_entry.duty_percent;
            end
            smcp_pkg::STATUS_STOP: begin
                fwd_next  = 1'b0;
                rev_next  = 1'b0;
                duty_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg   <= 1'b0;
            rev_reg   <= 1'b0;
            duty_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (queue_pop) begin
                fwd_reg   <= fwd_next;
                rev_reg   <= rev_next;
                duty_reg  <= duty_next;
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (queue_pop) begin
            status_reg <= queue_entry.status;
            cmd_reg    <= queue_entry.command_char;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, cmd_reg, duty_reg, rev_reg, fwd_reg, status_reg};

endmodule

// File: hdl/serial_motor_command_parser.sv
// ---------------------------------------------------------------------------
// serial_motor_command_parser
// Line-oriented motor command parser for received serial characters.
// ---------------------------------------------------------------------------
//  channel | dir | width | content
//  --------+-----+-------+-----------------------------------------------
//  s_      | in  |  8    | rx_byte, one received character per request
//  m_      | out | 24    | status, forward/reverse drive, duty, command
//
//  One character per cycle while the command queue is not full; a character request never waits on parsing.
//  A newline with a command is queued, then moved into the result register.
//  Reset (aresetn low, synchronous) clears the line state, drive levels
//  and the command queue.
//  s_tready drops only when the four-entry command queue is full, i.e.
//  when m_tready has been held low across several command lines.
// ---------------------------------------------------------------------------
`include "serial_motor_command_parser_macros.svh"

module serial_motor_command_parser #(
    parameter int LINE_BUFFER_BYTES = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input characters
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] rx_byte
    // command results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] status, [2] forward_drive, [3] reverse_drive,
    // [10:4] duty_percent, [18:11] command_char, [23:19] zero
    output logic [smcp_pkg::TDATA_OUT_W-1:0]    m_tdata
);

    logic                 push_valid;
    smcp_pkg::cmd_entry_t push_entry;
    logic                 queue_full;
    logic                 queue_pop;
    logic                 queue_empty;
    smcp_pkg::cmd_entry_t queue_entry;

    // Front: character parse, command classify on newline.
    smcp_front #(
        .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .queue_full (queue_full)
    );

    // Queue decouples parser from output back-pressure.
    smcp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push_valid),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (queue_pop),
        .pop_entry  (queue_entry),
        .empty      (queue_empty)
    );

    // Back: drive level update and result register.
    smcp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (queue_empty),
        .queue_entry (queue_entry),
        .queue_pop   (queue_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Results never drive both direction pins.
    `SMCP_CHECK(a_dir_exclusive, m_tvalid |-> !(m_tdata[2] && m_tdata[3]), "both drive pins set")

    // Duty stays within whole percent range.
    `SMCP_CHECK(a_duty_range, m_tvalid |-> (m_tdata[10:4] <= 7'd100), "duty above 100")

    // A stop result leaves the motor idle.
    `SMCP_CHECK(a_stop_idle, (m_tvalid && (m_tdata[1:0] == smcp_pkg::STATUS_STOP)) |-> ((m_tdata[10:2] == 9'd0)), "stop not idle")

    // No result right after reset.
    `SMCP_CHECK_ALWAYS(a_reset_quiet, !aresetn |=> !m_tvalid, "result after reset")

endmodule
